@@ hw/rtl/fm_polar_discriminator_assert.svh @@
// Assertion macros for the FM polar discriminator.
// Expects signals clk and rst_n in the scope of use.
`ifndef FM_POLAR_DISCRIMINATOR_ASSERT_SVH
`define FM_POLAR_DISCRIMINATOR_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define FPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define FPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/fpd_pkg.sv @@
// Package for the FM polar discriminator: widths, register indexes,
// reset values and the CORDIC arctangent table. No dependencies.
package fpd_pkg;

    localparam int SAMPLE_W      = 8;
    localparam int CENTRED_W     = 9;
    localparam int PRODUCT_W     = 18;
    localparam int XY_W          = PRODUCT_W + 16 + 3;
    localparam int Z_W           = 34;
    localparam int GAIN_W        = 13;
    localparam int DECIM_W       = 7;
    localparam int PHASE_W       = 6;
    localparam int AUDIO_W       = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = GAIN_W;
    localparam int IN_TDATA_W    = 2 * SAMPLE_W;
    localparam int OUT_TDATA_W   = ((AUDIO_W + 7) / 8) * 8;
    localparam int ATAN_ENTRIES  = 24;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_BITS_DEF    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECIM = CFG_IDX_W'(1);

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(2621);
    localparam logic [DECIM_W-1:0] DECIM_RESET = DECIM_W'(32);
    localparam logic [DECIM_W-1:0] DECIM_MAX   = DECIM_W'(64);

    // atan(2^-i), 2^31 is pi
    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

@@ hw/rtl/fm_polar_discriminator.sv @@
// FM polar discriminator: conjugate product, pipelined CORDIC atan2,
// gain scaling, decimation. Depends on fpd_pkg and the assertion header.
//
// Usage:
//   Slave stream s_*: one I/Q byte pair per word (I in bits 7:0, Q in 15:8).
//   Master stream m_*: one signed 17-bit audio word per kept sample.
//   cfg_*: register writes, index 0 deviation gain (unsigned Q1.12), index 1
//   decimation factor; cfg_ready is always high. Write only while idle.
// Every accepted word updates the previous-sample state; only the first
// word of each decimation group travels down the pipeline.
// Throughput: one input word per cycle unless the skid is full, set by the
// one-stage-per-iteration CORDIC pipeline and a single gain multiplier stage.
// Path: input, conjugate-product and pre-rotation registers, the CORDIC
// stages, angle register, gain product register, then output register.
// Reset: previous sample and decimation phase clear to zero, gain 2621,
// factor 32, pipeline and output empty.
// Stall: a two-entry output (register plus skid) absorbs a stall; once the
// skid holds a word the whole pipeline and s_tready hold until it drains.
module fm_polar_discriminator #(
    parameter int CORDIC_STAGES = fpd_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_BITS    = fpd_pkg::ANGLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fpd_pkg::IN_TDATA_W-1:0]     s_tdata,   // in_phase_byte, quadrature_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fpd_pkg::OUT_TDATA_W-1:0]    m_tdata,   // audio_sample, zero pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fpd_pkg::*;

    localparam int SH       = 32 - ANGLE_BITS;
    localparam int PROD_W   = ANGLE_BITS + GAIN_W + 1;
    localparam int ASH      = ANGLE_BITS - 4;
    localparam int SHIFTED_W = PROD_W + 1 - ASH;
    localparam int SUM_W    = PRODUCT_W + 1;

    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(64'sd1073741824);
    localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(64'sd1 <<< (SH - 1));
    localparam logic signed [PROD_W:0] A_HALF   = (PROD_W + 1)'(64'sd1 <<< (ASH - 1));
    localparam logic signed [SHIFTED_W-1:0] AUDIO_HI = SHIFTED_W'(64'sd65535);
    localparam logic signed [SHIFTED_W-1:0] AUDIO_LO = SHIFTED_W'(-64'sd65536);

    // configuration
    logic [GAIN_W-1:0]  gain_reg;
    logic [DECIM_W-1:0] decim_reg;

    // previous sample and decimation position
    logic signed [CENTRED_W-1:0] prior_i_reg, prior_q_reg;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic [DECIM_W-1:0]          factor_eff, phase_inc;

    // pipeline
    logic                         en, s_accept;
    logic signed [CENTRED_W-1:0]  ci_next, cq_next;
    logic                         a_valid_reg;
    logic signed [CENTRED_W-1:0]  a_ci_reg, a_cq_reg, a_pi_reg, a_pq_reg;
    logic                         b_valid_reg;
    logic signed [PRODUCT_W-1:0]  b_re_reg, b_im_reg;
    logic signed [PRODUCT_W:0]    re_next, im_next;
    logic signed [XY_W-1:0]       x0, y0;

    logic                         cv_reg [CORDIC_STAGES+1];
    logic                         cz_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]       cx_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]       cy_reg [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]        ca_reg [CORDIC_STAGES+1];

    logic                         ang_valid_reg;
    logic signed [ANGLE_BITS-1:0] ang_reg;
    logic signed [Z_W-1:0]        z_round;
    logic                         mul_valid_reg;
    logic signed [PROD_W-1:0]     mul_reg;
    logic signed [PROD_W:0]       a_round;
    logic signed [SHIFTED_W-1:0]  a_shift;
    logic signed [AUDIO_W-1:0]    audio;

    // output register and skid
    logic                         out_valid_reg, skid_valid_reg;
    logic signed [AUDIO_W-1:0]    out_data_reg, skid_data_reg;
    logic                         out_free;
    logic                         skid_stall, drop_accept;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            decim_reg <= DECIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_GAIN:  gain_reg  <= cfg_data;
                CFG_IDX_DECIM: decim_reg <= cfg_data[DECIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // centre each byte as 2x - 255
    assign ci_next = CENTRED_W'(signed'({2'b00, s_tdata[SAMPLE_W-1:0], 1'b0}) - 11'sd255);
    assign cq_next = CENTRED_W'(signed'({2'b00, s_tdata[IN_TDATA_W-1:SAMPLE_W], 1'b0})
                                - 11'sd255);

    always_comb
    begin
        if (decim_reg == '0)
            factor_eff = DECIM_W'(1);
        else if (decim_reg > DECIM_MAX)
            factor_eff = DECIM_MAX;
        else
            factor_eff = decim_reg;
        phase_inc = {1'b0, phase_reg} + DECIM_W'(1);
        phase_next = (phase_inc >= factor_eff) ? '0 : phase_inc[PHASE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_i_reg <= '0;
            prior_q_reg <= '0;
            phase_reg   <= '0;
        end
        else if (s_accept)
        begin
            prior_i_reg <= ci_next;
            prior_q_reg <= cq_next;
            phase_reg   <= phase_next;
        end
    end

    // conjugate product
    assign re_next = SUM_W'(a_ci_reg) * SUM_W'(a_pi_reg) + SUM_W'(a_cq_reg) * SUM_W'(a_pq_reg);
    assign im_next = SUM_W'(a_cq_reg) * SUM_W'(a_pi_reg) - SUM_W'(a_ci_reg) * SUM_W'(a_pq_reg);

    // pre-rotation into the right half plane
    assign x0 = XY_W'(signed'({b_re_reg, 16'h0000}));
    assign y0 = XY_W'(signed'({b_im_reg, 16'h0000}));

    // round the angle and wrap to ANGLE_BITS
    assign z_round = ca_reg[CORDIC_STAGES] + Z_HALF;

    // scale to audio, round half up, saturate
    assign a_round = {mul_reg[PROD_W-1], mul_reg} + A_HALF;
    assign a_shift = a_round[PROD_W:ASH];
    always_comb
    begin
        if (a_shift > AUDIO_HI)
            audio = AUDIO_W'(AUDIO_HI);
        else if (a_shift < AUDIO_LO)
            audio = AUDIO_W'(AUDIO_LO);
        else
            audio = a_shift[AUDIO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            cv_reg[0]     <= 1'b0;
            ang_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= s_accept && (phase_reg == '0);
            b_valid_reg   <= a_valid_reg;
            cv_reg[0]     <= b_valid_reg;
            ang_valid_reg <= cv_reg[CORDIC_STAGES];
            mul_valid_reg <= ang_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ci_reg <= ci_next;
            a_cq_reg <= cq_next;
            a_pi_reg <= prior_i_reg;
            a_pq_reg <= prior_q_reg;
            b_re_reg <= re_next[PRODUCT_W-1:0];
            b_im_reg <= im_next[PRODUCT_W-1:0];
            cz_reg[0] <= (b_re_reg == '0) && (b_im_reg == '0);
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    cx_reg[0] <= y0;
                    cy_reg[0] <= -x0;
                    ca_reg[0] <= Z_QUARTER;
                end
                else
                begin
                    cx_reg[0] <= -y0;
                    cy_reg[0] <= x0;
                    ca_reg[0] <= -Z_QUARTER;
                end
            end
            else
            begin
                cx_reg[0] <= x0;
                cy_reg[0] <= y0;
                ca_reg[0] <= '0;
            end
            ang_reg <= cz_reg[CORDIC_STAGES] ? '0 : z_round[31:SH];
            mul_reg <= PROD_W'(ang_reg) * PROD_W'(signed'({1'b0, gain_reg}));
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        localparam logic signed [Z_W-1:0] ATAN_K = signed'(Z_W'(ATAN_TABLE[k]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k+1] <= 1'b0;
            else if (en)
                cv_reg[k+1] <= cv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cz_reg[k+1] <= cz_reg[k];
                if (cy_reg[k] >= 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    ca_reg[k+1] <= ca_reg[k] + ATAN_K;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    ca_reg[k+1] <= ca_reg[k] - ATAN_K;
                end
            end
        end
    end

    // output register with skid
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= mul_valid_reg;
        end
        else if (mul_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_valid_reg ? skid_data_reg : audio;
        else if (en)
            skid_data_reg <= audio;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({1'b0, out_data_reg} & {1'b0, {AUDIO_W{1'b1}}});

    assign skid_stall  = skid_valid_reg && !m_tready;
    assign drop_accept = s_accept && (phase_reg != '0);

`include "fm_polar_discriminator_assert.svh"

    `FPD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid without output")
    `FPD_ASSERT_NEXT(a_skid_held, skid_stall, skid_valid_reg, "skid word lost while stalled")
    `FPD_ASSERT_NEXT(a_skid_data, skid_stall, $stable(skid_data_reg), "skid word changed")
    `FPD_ASSERT_NEXT(a_decim_drop, drop_accept, !a_valid_reg, "dropped word entered pipeline")

endmodule
